[rtl/core/hkdf_pkg.sv]
// ----------------------------------------------------------------------------
// hkdf_pkg
// Shared types and constants for the HKDF-SHA256 derivation core.
// ----------------------------------------------------------------------------
package hkdf_pkg;

  localparam int IdBytes     = 32;
  localparam int LabelBytes  = 16;
  localparam int MaxOutBytes = 64;

  localparam logic [2:0] CFG_SEED_HIGH  = 3'd0;
  localparam logic [2:0] CFG_SEED_LOW   = 3'd1;
  localparam logic [2:0] CFG_LABEL_HIGH = 3'd2;
  localparam logic [2:0] CFG_LABEL_LOW  = 3'd3;
  localparam logic [2:0] CFG_OUT_LENGTH = 3'd4;

  typedef struct packed {
    logic [7:0]  scope_mode;
    logic [5:0]  id_length;
    logic [63:0] id_word0;
    logic [63:0] id_word1;
    logic [63:0] id_word2;
    logic [63:0] id_word3;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  word_bytes;
    logic        last;
  } out_item_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  localparam logic [255:0] InitH = {32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
    32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

[rtl/core/hkdf_sha256_round.sv]
// ----------------------------------------------------------------------------
// hkdf_sha256_round
// One SHA-256 compression, one round per cycle, on a
// 16-word rolling message schedule.
// ----------------------------------------------------------------------------
module hkdf_sha256_round
  import hkdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [255:0] chain_in,
  input  logic [511:0] block_in,
  output logic         done,
  output logic [255:0] chain_out
);

  logic [31:0]  w_r [16];
  logic [31:0]  a_r [8];
  logic [255:0] h_r;
  logic [5:0]   t_r;
  logic         busy_r;
  logic         done_r;

  logic [31:0] x, y, s0, s1, wn, w_cur, e1, ch, e0, mj, t1;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  always_comb begin
    x  = w_r[1];
    y  = w_r[14];
    s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    s1 = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
    wn = w_r[0] + s0 + w_r[9] + s1;
    w_cur = w_r[0];
    e1 = rotr(a_r[4], 6) ^ rotr(a_r[4], 11) ^ rotr(a_r[4], 25);
    ch = (a_r[4] & a_r[5]) ^ (~a_r[4] & a_r[6]);
    t1 = a_r[7] + e1 + ch + round_k(t_r) + w_cur;
    e0 = rotr(a_r[0], 2) ^ rotr(a_r[0], 13) ^ rotr(a_r[0], 22);
    mj = (a_r[0] & a_r[1]) ^ (a_r[0] & a_r[2]) ^ (a_r[1] & a_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        t_r    <= '0;
      end else if (busy_r) begin
        t_r <= t_r + 6'd1;
        if (t_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Schedule window shifts each round; w_r[0] is the word for this round.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block_in[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) a_r[i] <= chain_in[255 - 32*i -: 32];
      h_r <= chain_in;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      a_r[7] <= a_r[6]; a_r[6] <= a_r[5]; a_r[5] <= a_r[4];
      a_r[4] <= a_r[3] + t1;
      a_r[3] <= a_r[2]; a_r[2] <= a_r[1]; a_r[1] <= a_r[0];
      a_r[0] <= t1 + e0 + mj;
    end
  end

  assign done = done_r;
  always_comb begin
    for (int i = 0; i < 8; i++)
      chain_out[255 - 32*i -: 32] = h_r[255 - 32*i -: 32] + a_r[i];
  end

endmodule

[rtl/core/hkdf_sha256_key_derivation_core.sv]
// ----------------------------------------------------------------------------
// hkdf_sha256_key_derivation_core
// HKDF-SHA256: extract from the configured seed, expand over label, scope
// mode and identifier, emit up to 64 derived bytes as 64-bit words.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in_     | in_valid, in_ready, in_data     | request in
//  out_    | out_valid, out_ready, out_data  | derived words out
//  cfg_    | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// Each request runs 8 to 13 SHA-256 compressions on one shared round unit,
// then emits one word per cycle while out_ready is high.
// in_ready is low from acceptance until the last word has been taken.
// Output stalls simply hold the word register. Reset is synchronous; the
// round unit's working registers need no reset.
// ----------------------------------------------------------------------------
module hkdf_sha256_key_derivation_core
  import hkdf_pkg::*;
#(
  parameter int ID_BYTES      = IdBytes,
  parameter int LABEL_BYTES   = LabelBytes,
  parameter int MAX_OUT_BYTES = MaxOutBytes
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  // Job steps: each is one full HMAC (inner hash, then outer hash)
  localparam logic [1:0] J_EXTRACT = 2'd0;
  localparam logic [1:0] J_EXPAND1 = 2'd1;
  localparam logic [1:0] J_EXPAND2 = 2'd2;

  logic [63:0] seed_high_r, seed_low_r, label_high_r, label_low_r;
  logic [6:0]  out_length_r;

  logic [2:0]   state_r;
  logic [1:0]   job_r;
  logic         outer_r;     // 0 inner hash, 1 outer hash
  logic [1:0]   blk_r;       // block index within current hash
  logic [1:0]   nblk_r;      // blocks in current hash
  logic [255:0] chain_r;
  logic [255:0] inner_r;
  logic [255:0] prk_r;
  logic [511:0] okm_r;
  logic [7:0]   mode_r;
  logic [5:0]   idn_r;
  logic [255:0] id_r;
  logic [6:0]   olen_r;
  logic [3:0]   widx_r;
  logic         start_r;
  logic         ovalid_r;
  out_item_t    odata_r;

  logic         rnd_done;
  logic [255:0] rnd_out;
  logic [511:0] blk_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_high_r <= '0; seed_low_r <= '0; label_high_r <= '0; label_low_r <= '0;
      out_length_r <= 7'd32;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SEED_HIGH:  seed_high_r  <= cfg_data;
        CFG_SEED_LOW:   seed_low_r   <= cfg_data;
        CFG_LABEL_HIGH: label_high_r <= cfg_data;
        CFG_LABEL_LOW:  label_low_r  <= cfg_data;
        CFG_OUT_LENGTH: out_length_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Inner-hash message bytes after the 64-byte pad, as a 1024-bit stream;
  // expand: [T(n-1)] || 0x01 || label || mode || id || n || 0x80 ... length.
  logic [1023:0] msg_bytes;
  logic [7:0]    msg_len;      // message length after the key block
  logic [10:0]   bit_len;
  logic [1:0]    inner_blocks;
  logic [7:0]    lab_b [16];
  logic [7:0]    ctr_b;
  logic          has_prev;

  always_comb begin
    logic [7:0] pos;
    msg_bytes = '0;
    has_prev = (job_r == J_EXPAND2);
    ctr_b = (job_r == J_EXPAND2) ? 8'd2 : 8'd1;
    for (int i = 0; i < 16; i++)
      lab_b[i] = (i < 8) ? label_high_r[63 - 8*i -: 8] : label_low_r[63 - 8*(i-8) -: 8];
    pos = 8'd0;
    if (job_r == J_EXTRACT) begin
      for (int i = 0; i < 8; i++) msg_bytes[1023 - 8*i -: 8] = seed_high_r[63 - 8*i -: 8];
      for (int i = 0; i < 8; i++) msg_bytes[959 - 8*i -: 8] = seed_low_r[63 - 8*i -: 8];
      msg_len = 8'd16;
    end else begin
      if (has_prev) begin
        for (int i = 0; i < 32; i++) msg_bytes[1023 - 8*i -: 8] = okm_r[511 - 8*i -: 8];
        pos = 8'd32;
      end
      msg_bytes[1023 - 8*pos -: 8] = 8'h01;
      for (int i = 0; i < LABEL_BYTES; i++)
        msg_bytes[1023 - 8*(pos + 8'd1 + i) -: 8] = lab_b[i];
      msg_bytes[1023 - 8*(pos + 8'd1 + LABEL_BYTES) -: 8] = mode_r;
      for (int i = 0; i < 32; i++)
        if (i < idn_r)
          msg_bytes[1023 - 8*(pos + 8'd2 + LABEL_BYTES + i) -: 8] = id_r[255 - 8*i -: 8];
      msg_len = pos + 8'(LABEL_BYTES + 3) + {2'b0, idn_r};
      msg_bytes[1023 - 8*(msg_len - 8'd1) -: 8] = ctr_b;
    end
    msg_bytes[1023 - 8*msg_len -: 8] = 8'h80;
    bit_len = {msg_len, 3'b0} + 11'd512;
    inner_blocks = (msg_len + 8'd9 > 8'd64) ? 2'd3 : 2'd2;
    if (inner_blocks == 2'd2) msg_bytes[527:512] = {5'b0, bit_len};
    else msg_bytes[15:0] = {5'b0, bit_len};
  end

  logic [255:0] key_c;
  assign key_c = (job_r == J_EXTRACT) ? 256'd0 : prk_r;

  always_comb begin
    if (blk_r == 2'd0)
      blk_data = {key_c ^ {32{outer_r ? 8'h5c : 8'h36}}, {32{outer_r ? 8'h5c : 8'h36}}};
    else if (outer_r)
      blk_data = {inner_r, 8'h80, 184'd0, 64'd768};
    else if (blk_r == 2'd1)
      blk_data = msg_bytes[1023:512];
    else
      blk_data = msg_bytes[511:0];
  end

  hkdf_sha256_round u_round (
    .clk(clk), .rst_n(rst_n), .start(start_r), .chain_in(chain_r),
    .block_in(blk_data), .done(rnd_done), .chain_out(rnd_out)
  );

  logic [6:0] olen_c;
  always_comb begin
    olen_c = out_length_r;
    if (olen_c == 7'd0) olen_c = 7'd1;
    if (olen_c > 7'(MAX_OUT_BYTES)) olen_c = 7'(MAX_OUT_BYTES);
  end

  logic [6:0] rem;
  assign rem = olen_r - {widx_r[2:0], 3'b0};

  assign in_ready = (state_r == S_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; start_r <= 1'b0; ovalid_r <= 1'b0;
      job_r <= J_EXTRACT; outer_r <= 1'b0; blk_r <= '0; nblk_r <= '0; widx_r <= '0;
    end else begin
      start_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r <= in_data.scope_mode;
          idn_r  <= (in_data.id_length > 6'(ID_BYTES)) ? 6'(ID_BYTES) : in_data.id_length;
          id_r   <= {in_data.id_word0, in_data.id_word1, in_data.id_word2, in_data.id_word3};
          olen_r <= olen_c;
          job_r <= J_EXTRACT; outer_r <= 1'b0; blk_r <= '0;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          chain_r <= InitH; blk_r <= '0;
          nblk_r <= outer_r ? 2'd2 : inner_blocks;
          start_r <= 1'b1; state_r <= S_RUN;
        end
        S_RUN: if (rnd_done) begin
          if (blk_r + 2'd1 != nblk_r) begin
            chain_r <= rnd_out; blk_r <= blk_r + 2'd1; start_r <= 1'b1;
          end else if (!outer_r) begin
            inner_r <= rnd_out; outer_r <= 1'b1; state_r <= S_LOAD;
          end else begin
            outer_r <= 1'b0; state_r <= S_LOAD;
            case (job_r)
              J_EXTRACT: begin prk_r <= rnd_out; job_r <= J_EXPAND1; end
              J_EXPAND1: begin
                okm_r[511:256] <= rnd_out;
                if (olen_r > 7'd32) job_r <= J_EXPAND2;
                else begin state_r <= S_EMIT; widx_r <= '0; end
              end
              default: begin
                okm_r[255:0] <= rnd_out; state_r <= S_EMIT; widx_r <= '0;
              end
            endcase
          end
        end
        S_EMIT: if (!ovalid_r || out_ready) begin
          if (ovalid_r && odata_r.last) begin
            ovalid_r <= 1'b0; state_r <= S_IDLE;
          end else begin
            ovalid_r <= 1'b1;
            odata_r.word_bytes <= (rem > 7'd8) ? 4'd8 : rem[3:0];
            odata_r.last <= (rem <= 7'd8);
            for (int i = 0; i < 8; i++)
              odata_r.out_word[63 - 8*i -: 8] <= (7'(i) < rem) ?
                okm_r[511 - 64*widx_r[2:0] - 8*i -: 8] : 8'h00;
            widx_r <= widx_r + 4'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

endmodule
